// ===== src/vector3_arithmetic_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vector ALU
// Shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vector ALU check failed");

// Consequent must hold in the cycle after the antecedent.
`define VAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vector ALU check failed");

`endif

// ===== src/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// vau_pkg
// Widths, operation codes, payload types and saturation helpers shared by the
// vector ALU modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

	localparam int W   = 32;
	localparam int F   = 16;
	localparam int SW  = 2 * W + 2;
	localparam int N   = W + F;
	localparam int LAT = 6 + W + N;

	typedef enum logic [2:0] {
		K_ADD   = 3'd0,
		K_SUB   = 3'd1,
		K_SCALE = 3'd2,
		K_DOT   = 3'd3,
		K_CROSS = 3'd4,
		K_NEG   = 3'd5,
		K_LEN   = 3'd6,
		K_NORM  = 3'd7
	} kind_t;

	typedef logic signed [W-1:0]   word_t;
	typedef logic signed [2*W-1:0] prod_t;
	typedef logic signed [SW-1:0]  wide_t;
	typedef logic [2*W-1:0]        usq_t;
	typedef logic [N-1:0]          num_t;

	typedef struct packed {
		word_t val;
		logic  ov;
	} sat_t;

	typedef struct packed {
		logic [W-2:0] val;
		logic         ov;
	} len_t;

	typedef struct packed {
		kind_t kind;
		word_t rx;
		word_t ry;
		word_t rz;
		word_t sc;
		logic  ov;
		word_t ax;
		word_t ay;
		word_t az;
	} side_t;

	typedef struct packed {
		side_t        sd;
		logic [W-1:0] len;
	} side2_t;

	localparam logic [W-1:0] ONE_Q = W'(1) << F;

	function automatic wide_t ext_w(input word_t v);
		return {{(SW - W){v[W-1]}}, v};
	endfunction

	function automatic wide_t ext_p(input prod_t v);
		return {{(SW - 2 * W){v[2*W-1]}}, v};
	endfunction

	// Clamp a wide signed value to the word range.
	function automatic sat_t sat(input wide_t v);
		sat_t            r;
		logic [SW-W:0]   hi;
		hi = v[SW-1:W-1];
		if (hi == '0 || hi == '1) begin
			r.val = v[W-1:0];
			r.ov  = 1'b0;
		end else begin
			r.ov  = 1'b1;
			r.val = v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic len_t lensat(input logic [W-1:0] l);
		len_t r;
		r.ov  = l[W-1];
		r.val = l[W-1] ? '1 : l[W-2:0];
		return r;
	endfunction

	// Apply the sign of the dividend to an unsigned quotient and clamp it.
	function automatic sat_t divsat(input num_t q, input logic neg);
		sat_t r;
		num_t lim;
		lim = {{(N-1){1'b0}}, 1'b1} << (W - 1);
		if (neg) begin
			r.ov  = (q > lim);
			r.val = r.ov ? {1'b1, {(W-1){1'b0}}} : -q[W-1:0];
		end else begin
			r.ov  = (q >= lim);
			r.val = r.ov ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] mag(input word_t v);
		return v[W-1] ? -v : v;
	endfunction

endpackage

`default_nettype wire

// ===== src/vau_if.sv =====
// ----------------------------------------------------------------------------
// vau_in_if / vau_out_if
// Valid/ready channels carrying one operation word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface vau_in_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           kind;
	vau_pkg::word_t       a_x;
	vau_pkg::word_t       a_y;
	vau_pkg::word_t       a_z;
	vau_pkg::word_t       b_x;
	vau_pkg::word_t       b_y;
	vau_pkg::word_t       b_z;
	vau_pkg::word_t       scale_factor;

	modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		input ready);
	modport sink (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		output ready);
endinterface

interface vau_out_if;
	logic                         valid;
	logic                         ready;
	vau_pkg::word_t               res_x;
	vau_pkg::word_t               res_y;
	vau_pkg::word_t               res_z;
	vau_pkg::word_t               res_scalar;
	logic [vau_pkg::W-2:0]        res_length;
	logic                         overflow;

	modport source (output valid, res_x, res_y, res_z, res_scalar, res_length, overflow,
		input ready);
	modport sink (input valid, res_x, res_y, res_z, res_scalar, res_length, overflow,
		output ready);
endinterface

`default_nettype wire

// ===== src/vau_lane.sv =====
// ----------------------------------------------------------------------------
// vau_lane
// One component lane: operand select, products, per-component result with
// saturation, and the square of that result for the length computation.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_lane (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire vau_pkg::kind_t          kind,
	input  wire vau_pkg::word_t          a,
	input  wire vau_pkg::word_t          b,
	input  wire vau_pkg::word_t          s,
	input  wire vau_pkg::word_t          xa0,
	input  wire vau_pkg::word_t          xb0,
	input  wire vau_pkg::word_t          xa1,
	input  wire vau_pkg::word_t          xb1,
	output vau_pkg::prod_t               p0,
	output vau_pkg::word_t               r,
	output logic                         ov,
	output vau_pkg::usq_t                rsq
);

	vau_pkg::word_t m0a, m0b;
	vau_pkg::prod_t p0_s2, p1_s2;
	vau_pkg::kind_t kind_s2;
	vau_pkg::word_t a_s2, b_s2;
	vau_pkg::wide_t w;
	vau_pkg::sat_t  st;
	vau_pkg::word_t r_s3, r_s4;
	logic           ov_s3, ov_s4;
	vau_pkg::prod_t sq;
	vau_pkg::usq_t  rsq_s4;

	always_comb begin
		case (kind) inside
			vau_pkg::K_SCALE: begin
				m0a = s;
				m0b = a;
			end
			vau_pkg::K_CROSS: begin
				m0a = xa0;
				m0b = xb0;
			end
			vau_pkg::K_LEN, vau_pkg::K_NORM: begin
				m0a = a;
				m0b = a;
			end
			default: begin
				m0a = a;
				m0b = b;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2   <= $signed(m0a) * $signed(m0b);
			p1_s2   <= $signed(xa1) * $signed(xb1);
			kind_s2 <= kind;
			a_s2    <= a;
			b_s2    <= b;
		end
	end

	always_comb begin
		case (kind_s2)
			vau_pkg::K_ADD:   w = vau_pkg::ext_w(a_s2) + vau_pkg::ext_w(b_s2);
			vau_pkg::K_SUB:   w = vau_pkg::ext_w(a_s2) - vau_pkg::ext_w(b_s2);
			vau_pkg::K_NEG:   w = -vau_pkg::ext_w(a_s2);
			vau_pkg::K_SCALE: w = vau_pkg::ext_p(p0_s2) >>> vau_pkg::F;
			vau_pkg::K_CROSS: w = (vau_pkg::ext_p(p0_s2) - vau_pkg::ext_p(p1_s2)) >>> vau_pkg::F;
			default:          w = '0;
		endcase
		st = vau_pkg::sat(w);
	end

	assign sq = r_s3 * r_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= st.val;
			ov_s3  <= st.ov;
			r_s4   <= r_s3;
			ov_s4  <= ov_s3;
			rsq_s4 <= vau_pkg::usq_t'(sq);
		end
	end

	assign p0  = p0_s2;
	assign r   = r_s4;
	assign ov  = ov_s4;
	assign rsq = rsq_s4;

endmodule

`default_nettype wire

// ===== src/vau_sqrt.sv =====
// ----------------------------------------------------------------------------
// vau_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_sqrt (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire vau_pkg::usq_t           n,
	output logic [vau_pkg::W-1:0]        root
);

	logic [2*vau_pkg::W:0] op_s  [1:vau_pkg::W];
	logic [2*vau_pkg::W:0] res_s [1:vau_pkg::W];

	for (genvar k = 0; k < vau_pkg::W; k++) begin : g_st
		localparam int SH = 2 * vau_pkg::W - 2 - 2 * k;
		logic [2*vau_pkg::W:0] op_c, res_c, bit_c, trial;
		logic                  ge;

		if (k == 0) begin : g_first
			assign op_c  = {1'b0, n};
			assign res_c = '0;
		end else begin : g_rest
			assign op_c  = op_s[k];
			assign res_c = res_s[k];
		end

		assign bit_c = {{(2*vau_pkg::W){1'b0}}, 1'b1} << SH;
		assign trial = res_c + bit_c;
		assign ge    = (op_c >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[k+1]  <= ge ? op_c - trial : op_c;
				res_s[k+1] <= ge ? (res_c >> 1) + bit_c : res_c >> 1;
			end
		end
	end

	assign root = res_s[vau_pkg::W][vau_pkg::W-1:0];

endmodule

`default_nettype wire

// ===== src/vau_div.sv =====
// ----------------------------------------------------------------------------
// vau_div
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_div (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire vau_pkg::num_t           num,
	input  wire logic [vau_pkg::W-1:0]   den,
	output vau_pkg::num_t                quo
);

	logic [vau_pkg::W-1:0] rem_s [1:vau_pkg::N];
	vau_pkg::num_t         nq_s  [1:vau_pkg::N];
	logic [vau_pkg::W-1:0] den_s [1:vau_pkg::N];

	for (genvar k = 0; k < vau_pkg::N; k++) begin : g_st
		logic [vau_pkg::W-1:0] rem_c, den_c;
		vau_pkg::num_t         nq_c;
		logic [vau_pkg::W:0]   t;
		logic [vau_pkg::W+1:0] sub;
		logic                  ge;

		if (k == 0) begin : g_first
			assign rem_c = '0;
			assign nq_c  = num;
			assign den_c = den;
		end else begin : g_rest
			assign rem_c = rem_s[k];
			assign nq_c  = nq_s[k];
			assign den_c = den_s[k];
		end

		// Shift in the next dividend bit and try to take the divisor away.
		assign t   = {rem_c, nq_c[vau_pkg::N-1]};
		assign sub = {1'b0, t} - {2'b00, den_c};
		assign ge  = ~sub[vau_pkg::W+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? sub[vau_pkg::W-1:0] : t[vau_pkg::W-1:0];
				nq_s[k+1]  <= {nq_c[vau_pkg::N-2:0], ge};
				den_s[k+1] <= den_c;
			end
		end
	end

	assign quo = nq_s[vau_pkg::N];

endmodule

`default_nettype wire

// ===== src/vector3_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Three-lane Q16.16 vector ALU with pipelined length and normalize.
// Throughput: one word per cycle while the output is not stalled; set by
// the fully pipelined lanes, root and divider units. A result held on the
// output stalls the whole pipeline.
// Reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_arithmetic_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vau_in_if.sink     in_ch,
	vau_out_if.source  out_ch
);

	logic [vau_pkg::LAT-1:0] vld_q;
	logic                    en;

	vau_pkg::kind_t kind_s1, kind_s2, kind_s3, kind_s4;
	vau_pkg::word_t ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1, s_s1;
	vau_pkg::word_t ax_s2, ay_s2, az_s2, ax_s3, ay_s3, az_s3, ax_s4, ay_s4, az_s4;

	vau_pkg::prod_t p0x, p0y, p0z;
	vau_pkg::word_t rx, ry, rz;
	logic           ovx, ovy, ovz;
	vau_pkg::usq_t  rsqx, rsqy, rsqz;

	vau_pkg::wide_t dsum;
	vau_pkg::sat_t  dsat;
	vau_pkg::word_t sc_s3, sc_s4;
	logic           ovd_s3, ovd_s4;
	vau_pkg::usq_t  asq_s3, asq_s4, n_s5;
	logic           vec_op;

	vau_pkg::side_t  side_ln [0:vau_pkg::W];
	logic [vau_pkg::W-1:0] root;
	vau_pkg::side2_t side2_in;
	vau_pkg::side2_t side2_ln [1:vau_pkg::N];
	vau_pkg::num_t   qx, qy, qz;

	vau_pkg::side2_t fin;
	vau_pkg::len_t   ls, lone;
	vau_pkg::sat_t   dx, dy, dz;
	vau_pkg::word_t  ox, oy, oz, osc;
	logic [vau_pkg::W-2:0] orl;
	logic            oov;

	vau_pkg::word_t        res_x_q, res_y_q, res_z_q, res_scalar_q;
	logic [vau_pkg::W-2:0] res_length_q;
	logic                  overflow_q;

	assign en          = ~vld_q[vau_pkg::LAT-1] | out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[vau_pkg::LAT-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= vau_pkg::kind_t'(in_ch.kind);
			ax_s1   <= in_ch.a_x;
			ay_s1   <= in_ch.a_y;
			az_s1   <= in_ch.a_z;
			bx_s1   <= in_ch.b_x;
			by_s1   <= in_ch.b_y;
			bz_s1   <= in_ch.b_z;
			s_s1    <= in_ch.scale_factor;
		end
	end

	vau_lane u_lane_x (
		.clk(clk), .en(en), .kind(kind_s1), .a(ax_s1), .b(bx_s1), .s(s_s1),
		.xa0(ay_s1), .xb0(bz_s1), .xa1(az_s1), .xb1(by_s1),
		.p0(p0x), .r(rx), .ov(ovx), .rsq(rsqx)
	);

	vau_lane u_lane_y (
		.clk(clk), .en(en), .kind(kind_s1), .a(ay_s1), .b(by_s1), .s(s_s1),
		.xa0(az_s1), .xb0(bx_s1), .xa1(ax_s1), .xb1(bz_s1),
		.p0(p0y), .r(ry), .ov(ovy), .rsq(rsqy)
	);

	vau_lane u_lane_z (
		.clk(clk), .en(en), .kind(kind_s1), .a(az_s1), .b(bz_s1), .s(s_s1),
		.xa0(ax_s1), .xb0(by_s1), .xa1(ay_s1), .xb1(bx_s1),
		.p0(p0z), .r(rz), .ov(ovz), .rsq(rsqz)
	);

	// Merge: the lanes' first products add up to the dot product, or to the
	// squared length of a for the length and normalize operations.
	assign dsum = vau_pkg::ext_p(p0x) + vau_pkg::ext_p(p0y) + vau_pkg::ext_p(p0z);
	assign dsat = vau_pkg::sat(dsum >>> vau_pkg::F);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			az_s2   <= az_s1;
			kind_s3 <= kind_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			az_s3   <= az_s2;
			sc_s3   <= (kind_s2 == vau_pkg::K_DOT) ? dsat.val : '0;
			ovd_s3  <= (kind_s2 == vau_pkg::K_DOT) & dsat.ov;
			asq_s3  <= dsum[2*vau_pkg::W-1:0];
			kind_s4 <= kind_s3;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			az_s4   <= az_s3;
			sc_s4   <= sc_s3;
			ovd_s4  <= ovd_s3;
			asq_s4  <= asq_s3;
		end
	end

	always_comb begin
		case (kind_s4) inside
			vau_pkg::K_DOT, vau_pkg::K_LEN, vau_pkg::K_NORM: vec_op = 1'b0;
			default:                                          vec_op = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5          <= vec_op ? rsqx + rsqy + rsqz : asq_s4;
			side_ln[0].kind <= kind_s4;
			side_ln[0].rx   <= rx;
			side_ln[0].ry   <= ry;
			side_ln[0].rz   <= rz;
			side_ln[0].sc   <= sc_s4;
			side_ln[0].ov   <= ovx | ovy | ovz | ovd_s4;
			side_ln[0].ax   <= ax_s4;
			side_ln[0].ay   <= ay_s4;
			side_ln[0].az   <= az_s4;
			for (int k = 0; k < vau_pkg::W; k++) begin
				side_ln[k+1] <= side_ln[k];
			end
		end
	end

	vau_sqrt u_sqrt (.clk(clk), .en(en), .n(n_s5), .root(root));

	assign side2_in.sd  = side_ln[vau_pkg::W];
	assign side2_in.len = root;

	vau_div u_div_x (
		.clk(clk), .en(en),
		.num({vau_pkg::mag(side2_in.sd.ax), {vau_pkg::F{1'b0}}}),
		.den(root), .quo(qx)
	);

	vau_div u_div_y (
		.clk(clk), .en(en),
		.num({vau_pkg::mag(side2_in.sd.ay), {vau_pkg::F{1'b0}}}),
		.den(root), .quo(qy)
	);

	vau_div u_div_z (
		.clk(clk), .en(en),
		.num({vau_pkg::mag(side2_in.sd.az), {vau_pkg::F{1'b0}}}),
		.den(root), .quo(qz)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side2_ln[1] <= side2_in;
			for (int k = 1; k < vau_pkg::N; k++) begin
				side2_ln[k+1] <= side2_ln[k];
			end
		end
	end

	assign fin  = side2_ln[vau_pkg::N];
	assign ls   = vau_pkg::lensat(fin.len);
	assign lone = vau_pkg::lensat(vau_pkg::ONE_Q);
	assign dx   = vau_pkg::divsat(qx, fin.sd.ax[vau_pkg::W-1]);
	assign dy   = vau_pkg::divsat(qy, fin.sd.ay[vau_pkg::W-1]);
	assign dz   = vau_pkg::divsat(qz, fin.sd.az[vau_pkg::W-1]);

	always_comb begin
		ox  = '0;
		oy  = '0;
		oz  = '0;
		osc = '0;
		orl = '0;
		oov = 1'b0;
		case (fin.sd.kind)
			vau_pkg::K_NORM: begin
				// A zero vector normalizes to zero with no overflow.
				if (fin.len != '0) begin
					ox  = dx.val;
					oy  = dy.val;
					oz  = dz.val;
					orl = lone.val;
					oov = dx.ov | dy.ov | dz.ov | lone.ov;
				end
			end
			vau_pkg::K_LEN: begin
				osc = {1'b0, ls.val};
				oov = ls.ov;
			end
			vau_pkg::K_DOT: begin
				osc = fin.sd.sc;
				oov = fin.sd.ov;
			end
			default: begin
				ox  = fin.sd.rx;
				oy  = fin.sd.ry;
				oz  = fin.sd.rz;
				orl = ls.val;
				oov = fin.sd.ov | ls.ov;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_x_q      <= ox;
			res_y_q      <= oy;
			res_z_q      <= oz;
			res_scalar_q <= osc;
			res_length_q <= orl;
			overflow_q   <= oov;
		end
	end

	assign out_ch.valid      = vld_q[vau_pkg::LAT-1];
	assign out_ch.res_x      = res_x_q;
	assign out_ch.res_y      = res_y_q;
	assign out_ch.res_z      = res_z_q;
	assign out_ch.res_scalar = res_scalar_q;
	assign out_ch.res_length = res_length_q;
	assign out_ch.overflow   = overflow_q;

endmodule

`default_nettype wire

// ===== src/vau_checker.sv =====
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks on the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector3_arithmetic_unit_assert.svh"

module vau_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire vau_pkg::word_t        res_x,
	input wire vau_pkg::word_t        res_y,
	input wire vau_pkg::word_t        res_z,
	input wire vau_pkg::word_t        res_scalar,
	input wire logic [vau_pkg::W-2:0] res_length,
	input wire logic                  overflow
);

	logic [5*vau_pkg::W-1:0] res_all;
	logic                    vec_zero;

	assign res_all  = {res_x, res_y, res_z, res_scalar, res_length, overflow};
	assign vec_zero = (res_x == '0) && (res_y == '0) && (res_z == '0);

	// A stalled result word stays put.
	`VAU_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(res_all))

	// With no result waiting, the unit always takes a new word.
	`VAU_ASSERT_NOW(a_ready, clk, arst_n, in_valid && !out_valid, in_ready)

	// A scalar result never comes with a vector result.
	`VAU_ASSERT_NOW(a_scalar, clk, arst_n, out_valid && res_scalar != '0, vec_zero && res_length == '0)

	// A zero vector has zero length.
	`VAU_ASSERT_NOW(a_zlen, clk, arst_n, out_valid && vec_zero, res_length == '0)

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.res_x(out_ch.res_x),
	.res_y(out_ch.res_y),
	.res_z(out_ch.res_z),
	.res_scalar(out_ch.res_scalar),
	.res_length(out_ch.res_length),
	.overflow(out_ch.overflow)
);

`default_nettype wire
